/* hdl/servo_eased_move_pwm_defines.svh */
// Assertion macros shared by the servo motion generator RTL.
`ifndef SERVO_EASED_MOVE_PWM_DEFINES_SVH
`define SERVO_EASED_MOVE_PWM_DEFINES_SVH
`ifndef ASSERT_OFF
// Clocked check, muted while reset is high
`define SEMP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also holds across reset
`define SEMP_ASSERT_RST(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SEMP_ASSERT(lbl, clk, rst, prop, msg)
`define SEMP_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

/* hdl/semp_pkg.sv */
// Package: widths, codes, reset values and helpers of the servo motion generator.
`default_nettype none
package semp_pkg;

   // field widths
   localparam int ANGLE_W = 10;
   localparam int PULSE_W = 16;
   localparam int TIME_W  = 48;
   localparam int MS_W    = 16;
   localparam int TOTAL_W = 26;   // ms * 1000 fits below 2^26

   // stream and register port widths
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 40;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [TOTAL_W-1:0] MS_TO_US = 26'd1000;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_ANGLE_MIN = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_ANGLE_MAX = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_PULSE_MIN = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_PULSE_MAX = 2'd3;

   // request kinds
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_MOVE = 1'b1;

   // reset values
   localparam logic [ANGLE_W-1:0] ANGLE_MIN_RST = 10'd0;
   localparam logic [ANGLE_W-1:0] ANGLE_MAX_RST = 10'd180;
   localparam logic [PULSE_W-1:0] PULSE_MIN_RST = 16'd500;
   localparam logic [PULSE_W-1:0] PULSE_MAX_RST = 16'd2500;
   localparam logic [ANGLE_W-1:0] ANGLE_HOME    = 10'd90;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_CHECK,
      ST_DIV_T,
      ST_MUL_SQ,
      ST_MUL_CUBE,
      ST_MUL_STEP,
      ST_PULSE_SETUP,
      ST_MUL_PULSE,
      ST_DIV_PULSE,
      ST_FIN
   } state_type;

   // lower bound first, then upper bound
   function automatic logic [ANGLE_W-1:0] clamp_angle(input logic [ANGLE_W-1:0] a,
                                                      input logic [ANGLE_W-1:0] lo,
                                                      input logic [ANGLE_W-1:0] hi);
      logic [ANGLE_W-1:0] r;
      r = (a < lo) ? lo : a;
      if (r > hi) begin
         r = hi;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

/* hdl/servo_eased_move_pwm.sv */
// Top level: servo motion generator with ease-out-cubic moves and pulse width mapping.
//
// Usage: each request on req_ carries a timestamp in microseconds. A move
// request (req_tuser = 1) clamps the goal angle and either jumps there or
// starts a timed move; a tick request (req_tuser = 0) advances a running move
// along 1-(1-t)^3. Every request yields exactly one response on rsp_ with the
// pulse width for the current angle, both angles and the moving/updated flags.
// The user must write registers through csr_ only while no request is in
// flight; the block itself does not enforce this. Timing: one request at a
// time. The easing and pulse multiplies and divides run through a shift-add
// multiplier and a restoring divider that handle one bit per cycle. A tick
// during a running move divides elapsed by total time for t, then multiplies
// for (1-t)^2, (1-t)^3 and the eased step; a tick at or past the end, and any
// other request, goes straight to the pulse mapping. When angle_max is not
// above angle_min the pulse mapping is skipped. A new request is taken in the
// cycle after the response register is loaded, even while that response waits.
// Reset (synchronous): angles return to 90 degrees, no move, registers to
// their defaults, no response pending. A stalled receiver holds a finished
// response; the block waits with the next one until the register frees up.
`default_nettype none
`include "servo_eased_move_pwm_defines.svh"
module servo_eased_move_pwm #(
   parameter int FRAC_BITS = 16
) (
   input  wire                                  clock,
   input  wire                                  reset,
   // request: opcode
   input  wire                                  req_tuser,
   // request: now_us [47:0], goal_angle [57:48], move_ms [73:58], zero pad
   input  wire  [semp_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   // response: pulse_width_us [15:0], angle_now [25:16], angle_goal [35:26],
   //           in_motion [36], updated [37], zero pad
   output logic [semp_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   // register writes
   input  wire                                  csr_we,
   input  wire  [semp_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  wire  [semp_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int ANGLE_W  = semp_pkg::ANGLE_W;
   localparam int PULSE_W  = semp_pkg::PULSE_W;
   localparam int TIME_W   = semp_pkg::TIME_W;
   localparam int MS_W     = semp_pkg::MS_W;
   localparam int TOTAL_W  = semp_pkg::TOTAL_W;
   localparam int GOAL_LSB = TIME_W;
   localparam int MS_LSB   = TIME_W + ANGLE_W;
   localparam int NUM_W    = ANGLE_W + PULSE_W;

   // Q1.FRAC: FRAC_BITS fraction bits and one integer bit for the value one
   localparam int ONE_W = FRAC_BITS + 1;
   // multiplicand, multiplier and product widths of the serial multiplier
   localparam int MC_W  = (ONE_W > PULSE_W) ? ONE_W : PULSE_W;
   localparam int MP_W  = (ONE_W > ANGLE_W) ? ONE_W : ANGLE_W;
   localparam int PR_W  = MC_W + MP_W;
   // divider remainder and quotient shift widths
   localparam int RM_W  = TOTAL_W;
   localparam int LS_W  = (FRAC_BITS > PULSE_W) ? FRAC_BITS : PULSE_W;
   localparam int STEP_MAX = (MP_W > LS_W) ? MP_W : LS_W;
   localparam int CNT_W = $clog2(STEP_MAX + 1);

   localparam logic [ONE_W-1:0] ONE_Q  = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [PR_W:0]    HALF_Q = (PR_W + 1)'(1) << (FRAC_BITS - 1);

   // control and architectural state
   semp_pkg::state_type state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ANGLE_W-1:0]   amin_ff, amin_in, amax_ff, amax_in;
   logic [PULSE_W-1:0]   pmin_ff, pmin_in, pmax_ff, pmax_in;
   logic [ANGLE_W-1:0]   cur_ff, cur_in, target_ff, target_in, start_ff, start_in;
   logic [TIME_W-1:0]    st_ff, st_in;
   logic [MS_W-1:0]      dur_ff, dur_in;
   logic                 moving_ff, moving_in;

   // captured request
   logic                 op_ff, op_in;
   logic [TIME_W-1:0]    now_ff, now_in;
   logic [ANGLE_W-1:0]   goal_ff, goal_in;
   logic [MS_W-1:0]      ms_ff, ms_in;

   // working registers
   logic [TIME_W-1:0]    elapsed_ff, elapsed_in;
   logic [TOTAL_W-1:0]   total_ff, total_in;
   logic [PR_W-1:0]      prod_ff, prod_in;
   logic [MC_W-1:0]      mcand_ff, mcand_in;
   logic [RM_W-1:0]      rem_ff, rem_in, divisor_ff, divisor_in;
   logic [LS_W-1:0]      lsh_ff, lsh_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [ONE_W-1:0]     inv_ff, inv_in;
   logic                 dir_ff, dir_in, pup_ff, pup_in, upd_ff, upd_in;
   logic [PULSE_W-1:0]   pulse_ff, pulse_in;

   // response register
   logic [PULSE_W-1:0]   rsp_pulse_ff, rsp_pulse_in;
   logic [ANGLE_W-1:0]   rsp_now_ff, rsp_now_in, rsp_goal_ff, rsp_goal_in;
   logic                 rsp_motion_ff, rsp_motion_in, rsp_upd_ff, rsp_upd_in;

   // one step of the shift-add multiplier, LSB of the multiplier first
   logic [MC_W:0]        mul_sum;
   logic [PR_W-1:0]      mul_next;
   assign mul_sum  = {1'b0, prod_ff[PR_W-1:MP_W]} + (prod_ff[0] ? {1'b0, mcand_ff} : '0);
   assign mul_next = {mul_sum, prod_ff[MP_W-1:1]};

   // one step of the restoring divider
   logic [RM_W+1:0]      div_trial;
   logic                 div_ok;
   logic [RM_W-1:0]      rem_next;
   logic [LS_W-1:0]      lsh_next;
   assign div_trial = {1'b0, rem_ff, lsh_ff[LS_W-1]} - {2'b00, divisor_ff};
   assign div_ok    = ~div_trial[RM_W+1];
   assign rem_next  = div_ok ? div_trial[RM_W-1:0] : {rem_ff[RM_W-2:0], lsh_ff[LS_W-1]};
   assign lsh_next  = {lsh_ff[LS_W-2:0], div_ok};
   logic                 cnt_done;
   assign cnt_done  = (cnt_ff == '0);

   // clamps and finishing arithmetic
   logic [ANGLE_W-1:0]   goal_c, target_c, cur_c;
   assign goal_c   = semp_pkg::clamp_angle(goal_ff, amin_ff, amax_ff);
   assign target_c = semp_pkg::clamp_angle(target_ff, amin_ff, amax_ff);
   assign cur_c    = semp_pkg::clamp_angle(cur_ff, amin_ff, amax_ff);

   logic [ONE_W-1:0]     inv_t, sq_w, cube_w, eased_w;
   assign inv_t   = ONE_Q - ONE_W'(lsh_ff[FRAC_BITS-1:0]);
   assign sq_w    = prod_ff[FRAC_BITS +: ONE_W];
   assign cube_w  = prod_ff[FRAC_BITS +: ONE_W];
   assign eased_w = ONE_Q - cube_w;

   logic                 dir_w;
   logic [ANGLE_W-1:0]   diff_w, q_step, step_angle;
   logic [PR_W:0]        mag_r;
   assign dir_w      = (target_ff >= start_ff);
   assign diff_w     = dir_w ? (target_ff - start_ff) : (start_ff - target_ff);
   assign mag_r      = {1'b0, prod_ff} + HALF_Q;
   assign q_step     = mag_r[FRAC_BITS +: ANGLE_W];
   assign step_angle = dir_ff ? (start_ff + q_step) : (start_ff - q_step);

   logic                 pup_w;
   logic [PULSE_W-1:0]   pd_w, pulse_q;
   logic [ANGLE_W-1:0]   off_w;
   logic [NUM_W-1:0]     num_w;
   assign pup_w   = (pmax_ff >= pmin_ff);
   assign pd_w    = pup_w ? (pmax_ff - pmin_ff) : (pmin_ff - pmax_ff);
   assign off_w   = cur_c - amin_ff;
   assign num_w   = prod_ff[NUM_W-1:0];
   assign pulse_q = lsh_ff[PULSE_W-1:0];

   // sequencer: next state and datapath loads
   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      amin_in       = amin_ff;
      amax_in       = amax_ff;
      pmin_in       = pmin_ff;
      pmax_in       = pmax_ff;
      cur_in        = cur_ff;
      target_in     = target_ff;
      start_in      = start_ff;
      st_in         = st_ff;
      dur_in        = dur_ff;
      moving_in     = moving_ff;
      op_in         = op_ff;
      now_in        = now_ff;
      goal_in       = goal_ff;
      ms_in         = ms_ff;
      elapsed_in    = elapsed_ff;
      total_in      = total_ff;
      prod_in       = prod_ff;
      mcand_in      = mcand_ff;
      rem_in        = rem_ff;
      divisor_in    = divisor_ff;
      lsh_in        = lsh_ff;
      cnt_in        = cnt_ff;
      inv_in        = inv_ff;
      dir_in        = dir_ff;
      pup_in        = pup_ff;
      upd_in        = upd_ff;
      pulse_in      = pulse_ff;
      rsp_pulse_in  = rsp_pulse_ff;
      rsp_now_in    = rsp_now_ff;
      rsp_goal_in   = rsp_goal_ff;
      rsp_motion_in = rsp_motion_ff;
      rsp_upd_in    = rsp_upd_ff;

      // register writes
      if (csr_we) begin
         case (csr_addr)
            semp_pkg::REG_ANGLE_MIN: amin_in = csr_wdata[ANGLE_W-1:0];
            semp_pkg::REG_ANGLE_MAX: amax_in = csr_wdata[ANGLE_W-1:0];
            semp_pkg::REG_PULSE_MIN: pmin_in = csr_wdata[PULSE_W-1:0];
            semp_pkg::REG_PULSE_MAX: pmax_in = csr_wdata[PULSE_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         semp_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tuser;
               now_in   = req_tdata[TIME_W-1:0];
               goal_in  = req_tdata[GOAL_LSB +: ANGLE_W];
               ms_in    = req_tdata[MS_LSB +: MS_W];
               state_in = semp_pkg::ST_DECODE;
            end
         end

         semp_pkg::ST_DECODE: begin
            if (op_ff == semp_pkg::OP_MOVE) begin
               moving_in = 1'b0;
               target_in = goal_c;
               upd_in    = 1'b1;
               if (ms_ff == '0 || goal_c == cur_ff) begin
                  cur_in = goal_c;
               end else begin
                  start_in  = cur_ff;
                  st_in     = now_ff;
                  dur_in    = ms_ff;
                  moving_in = 1'b1;
               end
               state_in = semp_pkg::ST_PULSE_SETUP;
            end else if (moving_ff) begin
               upd_in     = 1'b1;
               elapsed_in = (now_ff >= st_ff) ? (now_ff - st_ff) : '0;
               total_in   = TOTAL_W'(dur_ff) * semp_pkg::MS_TO_US;
               state_in   = semp_pkg::ST_CHECK;
            end else begin
               upd_in   = 1'b0;
               state_in = semp_pkg::ST_PULSE_SETUP;
            end
         end

         // time up: land on target, else start t = elapsed / total
         semp_pkg::ST_CHECK: begin
            if (total_ff == '0 || elapsed_ff >= TIME_W'(total_ff)) begin
               cur_in    = target_c;
               moving_in = 1'b0;
               state_in  = semp_pkg::ST_PULSE_SETUP;
            end else begin
               rem_in     = elapsed_ff[RM_W-1:0];
               divisor_in = total_ff;
               lsh_in     = '0;
               cnt_in     = CNT_W'(FRAC_BITS);
               state_in   = semp_pkg::ST_DIV_T;
            end
         end

         semp_pkg::ST_DIV_T: begin
            if (!cnt_done) begin
               rem_in = rem_next;
               lsh_in = lsh_next;
               cnt_in = cnt_ff - 1'b1;
            end else begin
               inv_in   = inv_t;
               mcand_in = MC_W'(inv_t);
               prod_in  = PR_W'(inv_t);
               cnt_in   = CNT_W'(MP_W);
               state_in = semp_pkg::ST_MUL_SQ;
            end
         end

         semp_pkg::ST_MUL_SQ: begin
            if (!cnt_done) begin
               prod_in = mul_next;
               cnt_in  = cnt_ff - 1'b1;
            end else begin
               mcand_in = MC_W'(sq_w);
               prod_in  = PR_W'(inv_ff);
               cnt_in   = CNT_W'(MP_W);
               state_in = semp_pkg::ST_MUL_CUBE;
            end
         end

         semp_pkg::ST_MUL_CUBE: begin
            if (!cnt_done) begin
               prod_in = mul_next;
               cnt_in  = cnt_ff - 1'b1;
            end else begin
               dir_in   = dir_w;
               mcand_in = MC_W'(eased_w);
               prod_in  = PR_W'(diff_w);
               cnt_in   = CNT_W'(MP_W);
               state_in = semp_pkg::ST_MUL_STEP;
            end
         end

         // eased step, rounded half away from zero
         semp_pkg::ST_MUL_STEP: begin
            if (!cnt_done) begin
               prod_in = mul_next;
               cnt_in  = cnt_ff - 1'b1;
            end else begin
               cur_in   = semp_pkg::clamp_angle(step_angle, amin_ff, amax_ff);
               state_in = semp_pkg::ST_PULSE_SETUP;
            end
         end

         // pulse = pmin +/- off * |pmax - pmin| / span
         semp_pkg::ST_PULSE_SETUP: begin
            if (amax_ff <= amin_ff) begin
               pulse_in = pmin_ff;
               state_in = semp_pkg::ST_FIN;
            end else begin
               divisor_in = RM_W'(amax_ff - amin_ff);
               pup_in     = pup_w;
               mcand_in   = MC_W'(pd_w);
               prod_in    = PR_W'(off_w);
               cnt_in     = CNT_W'(MP_W);
               state_in   = semp_pkg::ST_MUL_PULSE;
            end
         end

         semp_pkg::ST_MUL_PULSE: begin
            if (!cnt_done) begin
               prod_in = mul_next;
               cnt_in  = cnt_ff - 1'b1;
            end else begin
               // high part is below the span since off <= span
               rem_in   = RM_W'(num_w[NUM_W-1:PULSE_W]);
               lsh_in   = LS_W'(num_w[PULSE_W-1:0]) << (LS_W - PULSE_W);
               cnt_in   = CNT_W'(PULSE_W);
               state_in = semp_pkg::ST_DIV_PULSE;
            end
         end

         semp_pkg::ST_DIV_PULSE: begin
            if (!cnt_done) begin
               rem_in = rem_next;
               lsh_in = lsh_next;
               cnt_in = cnt_ff - 1'b1;
            end else begin
               pulse_in = pup_ff ? (pmin_ff + pulse_q) : (pmin_ff - pulse_q);
               state_in = semp_pkg::ST_FIN;
            end
         end

         // hand the result to the response register once it is free
         semp_pkg::ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_pulse_in  = pulse_ff;
               rsp_now_in    = cur_ff;
               rsp_goal_in   = target_ff;
               rsp_motion_in = moving_ff;
               rsp_upd_in    = upd_ff;
               rsp_valid_in  = 1'b1;
               state_in      = semp_pkg::ST_IDLE;
            end
         end

         default: state_in = semp_pkg::ST_IDLE;
      endcase
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= semp_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         amin_ff      <= semp_pkg::ANGLE_MIN_RST;
         amax_ff      <= semp_pkg::ANGLE_MAX_RST;
         pmin_ff      <= semp_pkg::PULSE_MIN_RST;
         pmax_ff      <= semp_pkg::PULSE_MAX_RST;
         cur_ff       <= semp_pkg::ANGLE_HOME;
         target_ff    <= semp_pkg::ANGLE_HOME;
         start_ff     <= '0;
         st_ff        <= '0;
         dur_ff       <= '0;
         moving_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         amin_ff      <= amin_in;
         amax_ff      <= amax_in;
         pmin_ff      <= pmin_in;
         pmax_ff      <= pmax_in;
         cur_ff       <= cur_in;
         target_ff    <= target_in;
         start_ff     <= start_in;
         st_ff        <= st_in;
         dur_ff       <= dur_in;
         moving_ff    <= moving_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      now_ff        <= now_in;
      goal_ff       <= goal_in;
      ms_ff         <= ms_in;
      elapsed_ff    <= elapsed_in;
      total_ff      <= total_in;
      prod_ff       <= prod_in;
      mcand_ff      <= mcand_in;
      rem_ff        <= rem_in;
      divisor_ff    <= divisor_in;
      lsh_ff        <= lsh_in;
      cnt_ff        <= cnt_in;
      inv_ff        <= inv_in;
      dir_ff        <= dir_in;
      pup_ff        <= pup_in;
      upd_ff        <= upd_in;
      pulse_ff      <= pulse_in;
      rsp_pulse_ff  <= rsp_pulse_in;
      rsp_now_ff    <= rsp_now_in;
      rsp_goal_ff   <= rsp_goal_in;
      rsp_motion_ff <= rsp_motion_in;
      rsp_upd_ff    <= rsp_upd_in;
   end

   // ports
   assign req_tready = (state_ff == semp_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(semp_pkg::RSP_DATA_W - PULSE_W - 2*ANGLE_W - 2){1'b0}},
                        rsp_upd_ff, rsp_motion_ff, rsp_goal_ff, rsp_now_ff, rsp_pulse_ff};

   // checks
   `SEMP_ASSERT_RST(a_reset_idle, clock, reset |=> (req_tready && !rsp_tvalid), "not idle after reset")
   `SEMP_ASSERT(a_move_duration, clock, reset, moving_ff |-> (dur_ff != '0), "move with zero duration")
   `SEMP_ASSERT(a_div_rem, clock, reset, (state_ff == semp_pkg::ST_DIV_T || state_ff == semp_pkg::ST_DIV_PULSE) |-> (rem_ff < divisor_ff), "divider remainder not below divisor")
   `SEMP_ASSERT(a_fin_hold, clock, reset, (state_ff == semp_pkg::ST_FIN && rsp_valid_ff && !rsp_tready) |=> (state_ff == semp_pkg::ST_FIN), "result left while response stalled")

endmodule
`default_nettype wire

/* bench/servo_eased_move_pwm_test.sv */
// Self-checking bench for the servo motion generator: directed table plus randomized move sequences.
`default_nettype none
module servo_eased_move_pwm_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC = 16;
   localparam logic [63:0] Q_ONE = 64'd1 << FRAC;
   localparam logic [63:0] Q_HALF = Q_ONE >> 1;

   // one response as the block packs it
   typedef struct packed {
      logic [semp_pkg::PULSE_W-1:0] pulse_us;
      logic [semp_pkg::ANGLE_W-1:0] deg_now;
      logic [semp_pkg::ANGLE_W-1:0] deg_goal;
      logic                         moving;
      logic                         updated;
   } servo_rsp_type;

   // one row of the directed table
   typedef struct {
      logic                         op;
      logic [semp_pkg::TIME_W-1:0]  now_us;
      logic [semp_pkg::ANGLE_W-1:0] goal;
      logic [semp_pkg::MS_W-1:0]    ms;
      bit                           typed;
      servo_rsp_type                want;
   } stim_row_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tuser = semp_pkg::OP_TICK;
   logic [semp_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                            req_tvalid = 1'b0;
   wire                             req_tready;
   wire  [semp_pkg::RSP_DATA_W-1:0] rsp_tdata;
   wire                             rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic                            csr_we = 1'b0;
   logic [semp_pkg::CSR_ADDR_W-1:0] csr_addr = semp_pkg::REG_ANGLE_MIN;
   logic [semp_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // no-idle stretch for both sides
   bit calm = 1'b0;
   int mismatches = 0;
   servo_rsp_type pending_rsp[$];
   servo_rsp_type head_rsp;

   // servo state and register copy
   logic [semp_pkg::ANGLE_W-1:0] cfg_amin = semp_pkg::ANGLE_MIN_RST;
   logic [semp_pkg::ANGLE_W-1:0] cfg_amax = semp_pkg::ANGLE_MAX_RST;
   logic [semp_pkg::PULSE_W-1:0] cfg_pmin = semp_pkg::PULSE_MIN_RST;
   logic [semp_pkg::PULSE_W-1:0] cfg_pmax = semp_pkg::PULSE_MAX_RST;
   logic [semp_pkg::ANGLE_W-1:0] cur_deg = semp_pkg::ANGLE_HOME;
   logic [semp_pkg::ANGLE_W-1:0] goal_deg = semp_pkg::ANGLE_HOME;
   logic [semp_pkg::ANGLE_W-1:0] from_deg = '0;
   logic [semp_pkg::TIME_W-1:0]  move_t0 = '0;
   logic [semp_pkg::MS_W-1:0]    move_len_ms = '0;
   logic                         moving = 1'b0;

   servo_eased_move_pwm dut (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),   // opcode
      .req_tdata  (req_tdata),   // now_us, goal_angle, move_ms, zero pad
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),   // pulse_width_us, angle_now, angle_goal, in_motion, updated
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // lower bound first, then upper
   function automatic logic [semp_pkg::ANGLE_W-1:0] clamp_deg(
         input logic [semp_pkg::ANGLE_W-1:0] a);
      logic [semp_pkg::ANGLE_W-1:0] r;
      r = (a < cfg_amin) ? cfg_amin : a;
      if (r > cfg_amax) r = cfg_amax;
      return r;
   endfunction

   // linear angle to pulse map, truncating toward zero
   function automatic logic [semp_pkg::PULSE_W-1:0] pulse_of(
         input logic [semp_pkg::ANGLE_W-1:0] a);
      logic [63:0] off, span;
      if (cfg_amax <= cfg_amin) return cfg_pmin;
      off = 64'(clamp_deg(a)) - 64'(cfg_amin);
      span = 64'(cfg_amax) - 64'(cfg_amin);
      if (cfg_pmax >= cfg_pmin)
         return 16'(64'(cfg_pmin) + off * (64'(cfg_pmax) - 64'(cfg_pmin)) / span);
      return 16'(64'(cfg_pmin) - off * (64'(cfg_pmin) - 64'(cfg_pmax)) / span);
   endfunction

   // 1 - (1 - t)^3 with truncating shifts
   function automatic logic [63:0] eased_q(input logic [63:0] t);
      logic [63:0] inv, sq, cube;
      inv = Q_ONE - t;
      sq = (inv * inv) >> FRAC;
      cube = (sq * inv) >> FRAC;
      return Q_ONE - cube;
   endfunction

   // advance the servo by one request and return its response
   function automatic servo_rsp_type step_servo(input logic op,
                                                input logic [semp_pkg::TIME_W-1:0] now,
                                                input logic [semp_pkg::ANGLE_W-1:0] goal,
                                                input logic [semp_pkg::MS_W-1:0] ms);
      logic [63:0] elapsed, total, frac, mag, q, a;
      logic [semp_pkg::ANGLE_W-1:0] clamped;
      logic upd;
      servo_rsp_type r;
      upd = 1'b0;
      if (op == semp_pkg::OP_MOVE) begin
         clamped = clamp_deg(goal);
         moving = 1'b0;
         goal_deg = clamped;
         if (ms == 0 || clamped == cur_deg) begin
            cur_deg = clamp_deg(clamped);
         end else begin
            from_deg = cur_deg;
            move_t0 = now;
            move_len_ms = ms;
            moving = 1'b1;
         end
         upd = 1'b1;
      end else if (moving) begin
         elapsed = (now >= move_t0) ? 64'(now - move_t0) : 64'd0;
         total = 64'(move_len_ms) * 64'd1000;
         if (total == 0 || elapsed >= total) begin
            cur_deg = clamp_deg(goal_deg);
            moving = 1'b0;
         end else begin
            frac = (elapsed << FRAC) / total;
            if (frac > Q_ONE) frac = Q_ONE;
            if (goal_deg >= from_deg) begin
               mag = (64'(goal_deg) - 64'(from_deg)) * eased_q(frac);
               q = (mag + Q_HALF) >> FRAC;
               a = 64'(from_deg) + q;
            end else begin
               mag = (64'(from_deg) - 64'(goal_deg)) * eased_q(frac);
               q = (mag + Q_HALF) >> FRAC;
               a = (q <= 64'(from_deg)) ? 64'(from_deg) - q : 64'd0;
            end
            cur_deg = clamp_deg(a[semp_pkg::ANGLE_W-1:0]);
         end
         upd = 1'b1;
      end
      r.pulse_us = pulse_of(cur_deg);
      r.deg_now = cur_deg;
      r.deg_goal = goal_deg;
      r.moving = moving;
      r.updated = upd;
      return r;
   endfunction

   function automatic stim_row_type plan_row(input logic op,
                                             input logic [semp_pkg::TIME_W-1:0] now,
                                             input logic [semp_pkg::ANGLE_W-1:0] goal,
                                             input logic [semp_pkg::MS_W-1:0] ms,
                                             input bit typed,
                                             input logic [semp_pkg::PULSE_W-1:0] pulse,
                                             input logic [semp_pkg::ANGLE_W-1:0] dnow,
                                             input logic [semp_pkg::ANGLE_W-1:0] dgoal,
                                             input logic mo, input logic up);
      stim_row_type row;
      row.op = op;
      row.now_us = now;
      row.goal = goal;
      row.ms = ms;
      row.typed = typed;
      row.want = '{pulse, dnow, dgoal, mo, up};
      return row;
   endfunction

   // offer one request, predict it once taken
   task automatic send_request(input logic op, input logic [semp_pkg::TIME_W-1:0] now,
                               input logic [semp_pkg::ANGLE_W-1:0] goal,
                               input logic [semp_pkg::MS_W-1:0] ms,
                               input bit typed, input servo_rsp_type want);
      servo_rsp_type predicted;
      while (!calm && $urandom_range(0, 99) < 26) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {6'd0, ms, goal, now};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = step_servo(op, now, goal, ms);
      pending_rsp.push_back(typed ? want : predicted);
   endtask

   task automatic write_reg(input logic [semp_pkg::CSR_ADDR_W-1:0] idx,
                            input logic [semp_pkg::CSR_DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         semp_pkg::REG_ANGLE_MIN: cfg_amin = val[semp_pkg::ANGLE_W-1:0];
         semp_pkg::REG_ANGLE_MAX: cfg_amax = val[semp_pkg::ANGLE_W-1:0];
         semp_pkg::REG_PULSE_MIN: cfg_pmin = val;
         semp_pkg::REG_PULSE_MAX: cfg_pmax = val;
         default: ;
      endcase
   endtask

   // drain, then rewrite all registers; angle writes carry junk above bit 9
   task automatic apply_config(input logic [semp_pkg::ANGLE_W-1:0] amin,
                               input logic [semp_pkg::ANGLE_W-1:0] amax,
                               input logic [semp_pkg::PULSE_W-1:0] pmin,
                               input logic [semp_pkg::PULSE_W-1:0] pmax);
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      write_reg(semp_pkg::REG_ANGLE_MIN, {6'($urandom), amin});
      write_reg(semp_pkg::REG_ANGLE_MAX, {6'($urandom), amax});
      write_reg(semp_pkg::REG_PULSE_MIN, pmin);
      write_reg(semp_pkg::REG_PULSE_MAX, pmax);
      csr_we <= 1'b0;
   endtask

   task automatic check_field(input string name, input logic [15:0] exp, input logic [15:0] act);
      if (exp !== act) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
         mismatches++;
      end
   endtask

   // response side: random stalls
   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(0, 99) >= 26);
   end

   // compare each taken response with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: response with no request pending, expected none, actual %h",
                     $time, rsp_tdata);
            mismatches++;
         end else begin
            head_rsp = pending_rsp.pop_front();
            check_field("pulse_width_us", head_rsp.pulse_us, rsp_tdata[15:0]);
            check_field("angle_now", head_rsp.deg_now, rsp_tdata[25:16]);
            check_field("angle_goal", head_rsp.deg_goal, rsp_tdata[35:26]);
            check_field("in_motion", head_rsp.moving, rsp_tdata[36]);
            check_field("updated", head_rsp.updated, rsp_tdata[37]);
         end
      end
   end

   initial begin
      #(8_000_000);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      stim_row_type plan[$];
      servo_rsp_type none;
      int n_items, ph, r, ticks, k, pick;
      logic [semp_pkg::TIME_W-1:0] t0, now_v;
      logic [semp_pkg::ANGLE_W-1:0] goal;
      logic [semp_pkg::MS_W-1:0] ms;
      logic [31:0] span_us, el;
      localparam logic [semp_pkg::TIME_W-1:0] T_MAX = '1;

      none = '0;
      // idle tick, clamped jumps, already-there move
      plan.push_back(plan_row(semp_pkg::OP_TICK, 0, 0, 0, 1, 1500, 90, 90, 0, 0));
      plan.push_back(plan_row(semp_pkg::OP_MOVE, 0, 1023, 0, 1, 2500, 180, 180, 0, 1));
      plan.push_back(plan_row(semp_pkg::OP_MOVE, 0, 0, 0, 1, 500, 0, 0, 0, 1));
      plan.push_back(plan_row(semp_pkg::OP_MOVE, 5, 0, 16'hFFFF, 1, 500, 0, 0, 0, 1));
      // rising move: start, midpoint, time running backwards, finish, idle
      plan.push_back(plan_row(semp_pkg::OP_MOVE, 1000, 180, 100, 1, 500, 0, 180, 1, 1));
      plan.push_back(plan_row(semp_pkg::OP_TICK, 1000, 0, 0, 1, 500, 0, 180, 1, 1));
      plan.push_back(plan_row(semp_pkg::OP_TICK, 51000, 0, 0, 0, 0, 0, 0, 0, 0));
      plan.push_back(plan_row(semp_pkg::OP_TICK, 500, 0, 0, 1, 500, 0, 180, 1, 1));
      plan.push_back(plan_row(semp_pkg::OP_TICK, 101000, 0, 0, 1, 2500, 180, 180, 0, 1));
      plan.push_back(plan_row(semp_pkg::OP_TICK, 200000, 1023, 16'hFFFF, 1,
                              2500, 180, 180, 0, 0));
      // falling move near the top of the time range
      plan.push_back(plan_row(semp_pkg::OP_MOVE, T_MAX - 500, 10, 1, 1, 2500, 180, 10, 1, 1));
      plan.push_back(plan_row(semp_pkg::OP_TICK, T_MAX, 0, 0, 0, 0, 0, 0, 0, 0));
      plan.push_back(plan_row(semp_pkg::OP_TICK, 0, 0, 0, 1, 2500, 180, 10, 1, 1));
      // longest move, falling then rising, cut short by a jump
      plan.push_back(plan_row(semp_pkg::OP_MOVE, 0, 0, 16'hFFFF, 1, 2500, 180, 0, 1, 1));
      plan.push_back(plan_row(semp_pkg::OP_TICK, 65534999, 0, 0, 0, 0, 0, 0, 0, 0));
      plan.push_back(plan_row(semp_pkg::OP_TICK, T_MAX, 0, 0, 1, 500, 0, 0, 0, 1));
      plan.push_back(plan_row(semp_pkg::OP_MOVE, 0, 1023, 16'hFFFF, 1, 500, 0, 180, 1, 1));
      plan.push_back(plan_row(semp_pkg::OP_TICK, 32767500, 0, 0, 0, 0, 0, 0, 0, 0));
      plan.push_back(plan_row(semp_pkg::OP_MOVE, 32767600, 90, 0, 1, 1500, 90, 90, 0, 1));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i])
         send_request(plan[i].op, plan[i].now_us, plan[i].goal, plan[i].ms,
                      plan[i].typed, plan[i].want);

      // random phases, each under its own register setting
      n_items = 0;
      for (ph = 0; ph < 6; ph++) begin
         case (ph)
            0: apply_config(10'd0, 10'd1023, 16'd0, 16'hFFFF);
            1: apply_config(10'd1023, 10'd0, 16'hFFFF, 16'd0);
            2: apply_config(10'd200, 10'd200, 16'd1000, 16'd2000);
            3: apply_config(10'd10, 10'd170, 16'd2500, 16'd500);
            4: apply_config(10'($urandom), 10'($urandom), 16'($urandom), 16'($urandom));
            default: apply_config(semp_pkg::ANGLE_MIN_RST, semp_pkg::ANGLE_MAX_RST,
                                  semp_pkg::PULSE_MIN_RST, semp_pkg::PULSE_MAX_RST);
         endcase
         while (n_items < (ph + 1) * 92) begin
            calm <= (n_items >= 250 && n_items < 330);
            r = $urandom_range(0, 99);
            if (r < 70) begin
               // move followed by ticks along its time line
               t0 = {16'($urandom), 32'($urandom)};
               goal = 10'($urandom);
               if (cfg_amin <= cfg_amax && $urandom_range(0, 1))
                  goal = 10'($urandom_range(cfg_amin, cfg_amax));
               pick = $urandom_range(0, 99);
               if (pick < 10) ms = 0;
               else if (pick < 75) ms = 16'($urandom_range(1, 40));
               else if (pick < 95) ms = 16'($urandom_range(41, 3000));
               else ms = 16'($urandom_range(3001, 65535));
               send_request(semp_pkg::OP_MOVE, t0, goal, ms, 0, none);
               span_us = 32'(ms) * 32'd1000;
               el = 0;
               ticks = $urandom_range(1, 8);
               for (k = 0; k < ticks; k++) begin
                  pick = $urandom_range(0, 99);
                  if (pick < 10) begin
                     now_v = t0 - 48'($urandom_range(1, 1000));
                  end else if (pick < 20) begin
                     el = span_us + $urandom_range(0, 5000);
                     now_v = t0 + 48'(el);
                  end else begin
                     el = el + $urandom_range(0, span_us / 3 + 1);
                     now_v = t0 + 48'(el);
                  end
                  send_request(semp_pkg::OP_TICK, now_v, 10'($urandom), 16'($urandom),
                               0, none);
               end
               n_items += 1 + ticks;
            end else if (r < 85) begin
               // stray tick at an arbitrary time
               send_request(semp_pkg::OP_TICK, {16'($urandom), 32'($urandom)},
                            10'($urandom), 16'($urandom), 0, none);
               n_items++;
            end else begin
               // move with arbitrary content
               send_request(semp_pkg::OP_MOVE, {16'($urandom), 32'($urandom)},
                            10'($urandom), 16'($urandom), 0, none);
               n_items++;
            end
         end
      end
      calm <= 1'b0;
      req_tvalid <= 1'b0;

      // drain, then give stray responses time to show up
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire
